>>> src/dfs_graph_walk_engine_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the depth-first walk engine
// Shared property forms used by the port-level checker.
// ---------------------------------------------------------------------------
`ifndef DFS_GRAPH_WALK_ENGINE_TOP_ASSERT_SVH
`define DFS_GRAPH_WALK_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, muted during reset
`define DGW_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("dgw: same-cycle check failed");

// Next-cycle implication, muted during reset
`define DGW_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("dgw: next-cycle check failed");

`endif

>>> src/dgw_pkg.sv
// ---------------------------------------------------------------------------
// dgw_pkg
// Widths, item codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package dgw_pkg;

  localparam int NODES     = 1024;
  localparam int EDGES     = 4096;
  localparam int STACK_CAP = NODES + 1;
  localparam int NODE_W    = 10;
  localparam int CUR_W     = 13;
  localparam int EDGE_AW   = 12;
  localparam int DEPTH_W   = 11;
  localparam int KIND_W    = 3;

  localparam logic [KIND_W-1:0] KIND_RANGE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_EDGE  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_START = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STEP  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_QUERY = 3'd4;

  typedef struct packed {
    logic accept;
    logic clear;
    logic push;
    logic push_sel_start;
    logic push_fin;
    logic pop;
    logic pop_load;
    logic query_rd;
    logic query_cap;
    logic out;
  } dgw_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic at_limit;
    logic depth_one;
    logic clr_last;
  } dgw_status_t;

endpackage

>>> src/dgw_ctrl.sv
// ---------------------------------------------------------------------------
// dgw_ctrl
// Sequencer: walks each request through memory reads, push and pop moves.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module dgw_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [2:0]            kind,
  input  dgw_pkg::dgw_status_t  status,
  output logic                  busy,
  output dgw_pkg::dgw_cmd_t     cmd
);
  import dgw_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE      = 14'b00000000000001,
    S_CLEAR     = 14'b00000000000010,
    S_STEP      = 14'b00000000000100,
    S_RANGE_RD  = 14'b00000000001000,
    S_CHECK     = 14'b00000000010000,
    S_EDGE_RD   = 14'b00000000100000,
    S_PUSH      = 14'b00000001000000,
    S_PUSH_FIN  = 14'b00000010000000,
    S_POP       = 14'b00000100000000,
    S_POP_LOAD  = 14'b00001000000000,
    S_QUERY_RD  = 14'b00010000000000,
    S_QUERY_CAP = 14'b00100000000000,
    S_REPORT    = 14'b01000000000000,
    S_OUT       = 14'b10000000000000
  } state_t;

  state_t state, state_next;
  logic   clr_for_start, clr_for_start_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_for_start <= 1'b0;
    end else begin
      state         <= state_next;
      clr_for_start <= clr_for_start_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next         = state;
    clr_for_start_next = clr_for_start;
    cmd                = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          unique case (kind)
            KIND_START: begin
              state_next         = S_CLEAR;
              clr_for_start_next = 1'b1;
            end
            KIND_STEP:  state_next = S_STEP;
            KIND_QUERY: state_next = S_QUERY_RD;
            default:    state_next = S_REPORT;
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clr_last) begin
          state_next = clr_for_start ? S_PUSH : S_IDLE;
        end
      end
      S_STEP:     state_next = status.empty ? S_REPORT : S_RANGE_RD;
      S_RANGE_RD: state_next = S_CHECK;
      S_CHECK:    state_next = status.at_limit ? S_POP : S_EDGE_RD;
      S_EDGE_RD:  state_next = S_PUSH;
      S_PUSH: begin
        cmd.push           = 1'b1;
        cmd.push_sel_start = clr_for_start;
        clr_for_start_next = 1'b0;
        state_next         = status.full ? S_REPORT : S_PUSH_FIN;
      end
      S_PUSH_FIN: begin
        cmd.push_fin = 1'b1;
        state_next   = S_REPORT;
      end
      S_POP: begin
        cmd.pop    = 1'b1;
        state_next = status.depth_one ? S_REPORT : S_POP_LOAD;
      end
      S_POP_LOAD: begin
        cmd.pop_load = 1'b1;
        state_next   = S_RANGE_RD;
      end
      S_QUERY_RD: begin
        cmd.query_rd = 1'b1;
        state_next   = S_QUERY_CAP;
      end
      S_QUERY_CAP: begin
        cmd.query_cap = 1'b1;
        state_next    = S_REPORT;
      end
      S_REPORT: state_next = S_OUT;
      S_OUT: begin
        cmd.out    = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> src/dgw_datapath.sv
// ---------------------------------------------------------------------------
// dgw_datapath
// Graph tables, mark memories, traversal stack and result registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module dgw_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  dgw_pkg::dgw_cmd_t           cmd,
  output dgw_pkg::dgw_status_t        status,
  input  logic [2:0]                  kind,
  input  logic [11:0]                 row_index,
  input  logic [12:0]                 edge_first,
  input  logic [12:0]                 edge_limit,
  input  logic [9:0]                  edge_target,
  input  logic [9:0]                  query_node,
  input  logic [9:0]                  start_node,
  output logic                        done,
  output logic                        walk_active,
  output logic [9:0]                  top_node,
  output logic                        top_is_loop,
  output logic                        top_seen_before,
  output logic                        query_visited
);
  import dgw_pkg::*;

  logic [2*CUR_W-1:0]      range_mem [0:NODES-1];
  logic [NODE_W-1:0]       edge_mem  [0:EDGES-1];
  logic                    onst_mem  [0:NODES-1];
  logic                    fin_mem   [0:NODES-1];
  logic [NODE_W+CUR_W-1:0] stack_mem [0:STACK_CAP-1];

  logic [2*CUR_W-1:0]      range_rd;
  logic [NODE_W-1:0]       edge_rd;
  logic                    onst_rd, fin_rd;
  logic [NODE_W+CUR_W-1:0] stack_rd;

  logic [NODE_W-1:0]  cur_node;
  logic [CUR_W-1:0]   cur_pos;
  logic [DEPTH_W-1:0] depth;
  logic [NODE_W-1:0]  pend;
  logic [NODE_W-1:0]  q_node;
  logic [NODE_W-1:0]  clr_cnt;

  logic [NODE_W-1:0]  pend_node;
  logic [NODE_W-1:0]  range_addr, mark_addr;
  logic               push_ok, visited;
  logic [CUR_W-1:0]   lim_rd, first_rd;

  assign lim_rd   = range_rd[CUR_W-1:0];
  assign first_rd = range_rd[2*CUR_W-1:CUR_W];

  // Edge index beyond the table reads node zero
  assign pend_node = cmd.push_sel_start ? start_node :
                     (cur_pos < CUR_W'(EDGES)) ? edge_rd : '0;

  assign push_ok    = cmd.push && !status.full;
  assign range_addr = cmd.push ? pend_node : cur_node;
  assign mark_addr  = cmd.push ? pend_node : (cmd.query_rd ? q_node : cur_node);

  assign status.empty     = (depth == '0);
  assign status.full      = (depth == DEPTH_W'(STACK_CAP));
  assign status.at_limit  = (cur_pos == lim_rd);
  assign status.depth_one = (depth == DEPTH_W'(1));
  assign status.clr_last  = (clr_cnt == NODE_W'(NODES - 1));

  always_ff @(posedge clk) begin
    if (cmd.accept && kind == KIND_RANGE && {1'b0, row_index} < CUR_W'(NODES)) begin
      range_mem[row_index[NODE_W-1:0]] <= {edge_first, edge_limit};
    end
    range_rd <= range_mem[range_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && kind == KIND_EDGE) begin
      edge_mem[row_index[EDGE_AW-1:0]] <= edge_target;
    end
    edge_rd <= edge_mem[cur_pos[EDGE_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      onst_mem[clr_cnt] <= 1'b0;
    end else if (push_ok && !status.empty) begin
      onst_mem[cur_node] <= 1'b1;
    end else if (cmd.pop) begin
      onst_mem[cur_node] <= 1'b0;
    end
    onst_rd <= onst_mem[mark_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      fin_mem[clr_cnt] <= 1'b0;
    end else if (cmd.pop) begin
      fin_mem[cur_node] <= 1'b1;
    end
    fin_rd <= fin_mem[mark_addr];
  end

  always_ff @(posedge clk) begin
    if (push_ok && !status.empty) begin
      stack_mem[depth - DEPTH_W'(1)] <= {cur_node, cur_pos};
    end
    stack_rd <= stack_mem[depth - DEPTH_W'(2)];
  end

  // Below-node mark is written in the same cycle the new node is read
  assign visited = onst_rd || fin_rd || (!status.empty && pend == cur_node);

  always_ff @(posedge clk) begin
    if (rst) begin
      depth   <= '0;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= cmd.out;
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + NODE_W'(1);
        depth   <= '0;
      end else if (cmd.push_fin) begin
        depth <= depth + DEPTH_W'(1);
      end else if (cmd.pop) begin
        depth <= depth - DEPTH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      pend <= pend_node;
    end
    if (cmd.push_fin) begin
      cur_node <= pend;
      cur_pos  <= visited ? lim_rd : first_rd;
    end else if (cmd.pop_load) begin
      cur_node <= stack_rd[NODE_W+CUR_W-1:CUR_W];
      cur_pos  <= stack_rd[CUR_W-1:0] + CUR_W'(1);
    end
    if (cmd.accept) begin
      q_node        <= query_node;
      query_visited <= 1'b0;
    end else if (cmd.query_cap) begin
      query_visited <= onst_rd || fin_rd;
    end
    if (cmd.out) begin
      walk_active     <= !status.empty;
      top_node        <= status.empty ? '0 : cur_node;
      top_is_loop     <= !status.empty && onst_rd;
      top_seen_before <= !status.empty && (onst_rd || fin_rd);
    end
  end

endmodule

>>> src/dfs_graph_walk_engine_top.sv
// A start request clears the mark memories, then pushes the start node; a step pops
// finished nodes until one has an edge left and pushes its target, or empties the stack.
// Throughput: one request at a time, set by the sequence of single-port memory reads.
// Reset: synchronous; after rst falls the mark memories are cleared with busy high.
// Results appear on done for one cycle; the receiver cannot stall.
// ---------------------------------------------------------------------------
// dfs_graph_walk_engine_top
// Depth-first walk engine over a graph held in compressed adjacency form.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module dfs_graph_walk_engine_top (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [11:0] row_index,
  input  logic [12:0] edge_first,
  input  logic [12:0] edge_limit,
  input  logic [9:0]  edge_target,
  input  logic [9:0]  query_node,
  // result strobe and fields
  output logic        done,
  output logic        walk_active,
  output logic [9:0]  top_node,
  output logic        top_is_loop,
  output logic        top_seen_before,
  output logic        query_visited,
  // start node register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [9:0]  cfg_data
);
  import dgw_pkg::*;

  dgw_cmd_t          cmd;
  dgw_status_t       status;
  logic [NODE_W-1:0] start_node;

  // The register is always writable; the user must write it only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_node <= '0;
    end else if (cfg_valid && cfg_ready) begin
      start_node <= cfg_data;
    end
  end

  // Sequencer: decodes each request and steps the datapath
  dgw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .kind   (kind),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  // Tables, marks, stack and result registers
  dgw_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .kind            (kind),
    .row_index       (row_index),
    .edge_first      (edge_first),
    .edge_limit      (edge_limit),
    .edge_target     (edge_target),
    .query_node      (query_node),
    .start_node      (start_node),
    .done            (done),
    .walk_active     (walk_active),
    .top_node        (top_node),
    .top_is_loop     (top_is_loop),
    .top_seen_before (top_seen_before),
    .query_visited   (query_visited)
  );

endmodule

>>> src/dgw_checker.sv
// ---------------------------------------------------------------------------
// dgw_checker
// Port-level checks on the walk engine, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dfs_graph_walk_engine_top_assert.svh"
module dgw_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       walk_active,
  input logic [9:0] top_node,
  input logic       top_is_loop,
  input logic       top_seen_before
);

  `DGW_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)
  `DGW_ASSERT_NEXT(a_req_busy, clk, rst, start && !busy, busy)
  `DGW_ASSERT_NEXT(a_done_pulse, clk, rst, done, !done)
  `DGW_ASSERT_NOW(a_empty, clk, rst, done && !walk_active, top_node == '0 && !top_seen_before)
  `DGW_ASSERT_NOW(a_loop_seen, clk, rst, done && top_is_loop, top_seen_before)

endmodule

bind dfs_graph_walk_engine_top dgw_checker u_dgw_checker (
  .clk             (clk),
  .rst             (rst),
  .start           (start),
  .busy            (busy),
  .done            (done),
  .walk_active     (walk_active),
  .top_node        (top_node),
  .top_is_loop     (top_is_loop),
  .top_seen_before (top_seen_before)
);

>>> verif/dfs_graph_walk_engine_top_tb.sv
// ---------------------------------------------------------------------------
// dfs_graph_walk_engine_top_tb
// Self-checking bench for the depth-first walk engine. A predictor keeps its
// own adjacency tables, marks and stack, works out the one result each
// request causes, and a monitor compares every done strobe in arrival order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module dfs_graph_walk_engine_top_tb;
  import dgw_pkg::*;

  typedef struct packed {
    logic       walk_active;
    logic [9:0] top_node;
    logic       top_is_loop;
    logic       top_seen_before;
    logic       query_visited;
  } walk_status_t;

  localparam int LIMIT_CYCLES = 4000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  kind = '0;
  logic [11:0] row_index = '0;
  logic [12:0] edge_first = '0;
  logic [12:0] edge_limit = '0;
  logic [9:0]  edge_target = '0;
  logic [9:0]  query_node = '0;
  logic        done;
  logic        walk_active;
  logic [9:0]  top_node;
  logic        top_is_loop;
  logic        top_seen_before;
  logic        query_visited;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [9:0]  cfg_data = '0;

  dfs_graph_walk_engine_top dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the block's state
  logic [CUR_W-1:0]  sh_first [NODES];
  logic [CUR_W-1:0]  sh_limit [NODES];
  logic [NODE_W-1:0] sh_target [EDGES];
  bit                sh_on_stack [NODES];
  bit                sh_finished [NODES];
  logic [NODE_W-1:0] sh_nodes [STACK_CAP];
  logic [CUR_W-1:0]  sh_cursor [STACK_CAP];
  int                sh_depth;
  logic [NODE_W-1:0] sh_start_node;

  walk_status_t expected_status_q[$];
  int  mismatches = 0;
  int  cycles = 0;
  int  send_idle_pct;
  int  items_sent = 0;
  bit  timed_out = 1'b0;

  function automatic bit is_visited(logic [NODE_W-1:0] n);
    return sh_on_stack[n] || sh_finished[n];
  endfunction

  function automatic void push_walk(logic [NODE_W-1:0] n);
    if (sh_depth >= STACK_CAP) return;
    if (sh_depth > 0) sh_on_stack[sh_nodes[sh_depth-1]] = 1'b1;
    sh_nodes[sh_depth]  = n;
    sh_cursor[sh_depth] = is_visited(n) ? sh_limit[n] : sh_first[n];
    sh_depth++;
  endfunction

  function automatic void pop_walk();
    logic [NODE_W-1:0] n;
    n = sh_nodes[sh_depth-1];
    sh_finished[n] = 1'b1;
    sh_on_stack[n] = 1'b0;
    sh_depth--;
  endfunction

  function automatic logic [NODE_W-1:0] edge_dest(logic [CUR_W-1:0] e);
    return (e < EDGES) ? sh_target[e[EDGE_AW-1:0]] : '0;
  endfunction

  function automatic void advance_walk();
    logic [NODE_W-1:0] t;
    logic [CUR_W-1:0]  c;
    if (sh_depth == 0) return;
    t = sh_nodes[sh_depth-1];
    c = sh_cursor[sh_depth-1];
    if (c != sh_limit[t]) begin
      push_walk(edge_dest(c));
      return;
    end
    pop_walk();
    while (sh_depth > 0) begin
      t = sh_nodes[sh_depth-1];
      c = sh_cursor[sh_depth-1] + 1'b1;
      sh_cursor[sh_depth-1] = c;
      if (c != sh_limit[t]) begin
        push_walk(edge_dest(c));
        return;
      end
      pop_walk();
    end
  endfunction

  function automatic walk_status_t predict_status(logic [2:0] k, logic [11:0] row,
      logic [12:0] ef, logic [12:0] el, logic [9:0] et, logic [9:0] qn);
    walk_status_t s;
    s = '0;
    case (k)
      KIND_RANGE: if (row < NODES) begin
        sh_first[row[NODE_W-1:0]] = ef;
        sh_limit[row[NODE_W-1:0]] = el;
      end
      KIND_EDGE: if (row < EDGES) sh_target[row] = et;
      KIND_START: begin
        foreach (sh_on_stack[i]) begin
          sh_on_stack[i] = 1'b0;
          sh_finished[i] = 1'b0;
        end
        sh_depth = 0;
        push_walk(sh_start_node);
      end
      KIND_STEP:  advance_walk();
      KIND_QUERY: s.query_visited = is_visited(qn);
      default: ;
    endcase
    if (sh_depth > 0) begin
      s.walk_active     = 1'b1;
      s.top_node        = sh_nodes[sh_depth-1];
      s.top_is_loop     = sh_on_stack[s.top_node];
      s.top_seen_before = is_visited(s.top_node);
    end
    return s;
  endfunction

  always @(posedge clk) begin
    if (!rst) cycles <= cycles + 1;
  end

  // Check every strobed result against the oldest expectation
  always @(posedge clk) begin
    walk_status_t got, want;
    if (!rst && done) begin
      got = '{walk_active, top_node, top_is_loop, top_seen_before, query_visited};
      if (expected_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = expected_status_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  // Send one request; hold start until the block takes it
  task automatic send_request(logic [2:0] k, logic [11:0] row = '0, logic [12:0] ef = '0,
      logic [12:0] el = '0, logic [9:0] et = '0, logic [9:0] qn = '0);
    walk_status_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    kind        <= k;
    row_index   <= row;
    edge_first  <= ef;
    edge_limit  <= el;
    edge_target <= et;
    query_node  <= qn;
    do @(posedge clk); while (busy);
    want = predict_status(k, row, ef, el, et, qn);
    expected_status_q = {expected_status_q, want};
    items_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_start_node(logic [9:0] n);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    sh_start_node = n;
    cfg_valid <= 1'b0;
  endtask

  // Load a random graph over nodes 0..count-1 with up to fanout edges each,
  // and the range of each node and every edge it uses written so a walk never reads stale memory
  task automatic load_graph(int count, int fanout);
    int e;
    e = $urandom_range(EDGES - count * fanout - 1);
    for (int n = 0; n < count; n++) begin
      int deg;
      deg = $urandom_range(fanout);
      send_request(KIND_RANGE, 12'(n), 13'(e), 13'(e + deg));
      for (int j = 0; j < deg; j++)
        send_request(KIND_EDGE, 12'(e + j), '0, '0, 10'($urandom_range(count - 1)));
      e += deg;
    end
  endtask

  task automatic test_directed();
    // Full-scale range load, an out-of-range range load that is dropped, then edge loads at the top and bottom rows
    send_request(KIND_RANGE, 12'(NODES - 1), 13'h1FFF, 13'h1FFF);
    send_request(KIND_RANGE, 12'hFFF, 13'h1FFF, 13'h0);
    send_request(KIND_EDGE, 12'(EDGES - 1), '0, '0, 10'h3FF);
    send_request(KIND_EDGE, 12'h000, '0, '0, 10'h3FF);
    // Tiny loop: 0 -> 1 -> 0 and a self loop on 1
    send_request(KIND_RANGE, 12'd0, 13'd0, 13'd1);
    send_request(KIND_RANGE, 12'd1, 13'd1, 13'd3);
    send_request(KIND_EDGE, 12'd0, '0, '0, 10'd1);
    send_request(KIND_EDGE, 12'd1, '0, '0, 10'd0);
    send_request(KIND_EDGE, 12'd2, '0, '0, 10'd1);
    send_request(KIND_STEP);                 // step on empty stack
    write_start_node(10'd0);
    send_request(KIND_START);
    repeat (8) send_request(KIND_STEP);      // walk out and past the end
    send_request(KIND_QUERY, '0, '0, '0, '0, 10'd1);
    send_request(KIND_QUERY, '0, '0, '0, '0, 10'h3FF);
    send_request(3'd5, 12'hFFF, 13'h1FFF, 13'h1FFF, 10'h3FF, 10'h3FF);
    send_request(3'd7);
    // Cursor wrap: node 1023 spans 8191 -> edge 8191 is out of range (target 0)
    send_request(KIND_RANGE, 12'(NODES - 1), 13'h1FFF, 13'h0000);
    send_request(KIND_RANGE, 12'd0, 13'd0, 13'd0);
    write_start_node(10'h3FF);
    send_request(KIND_START);
    repeat (3) send_request(KIND_STEP);
  endtask

  task automatic test_random_walks(int items);
    int stop_at;
    stop_at = items_sent + items;
    while (items_sent < stop_at) begin
      int count;
      count = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(2, 12);
      if (count > (stop_at - items_sent) / 3) count = (stop_at - items_sent) / 3;
      if (count < 2) count = 2;
      load_graph(count, 4);
      write_start_node(10'($urandom_range(count - 1)));
      send_request(KIND_START);
      for (int s = 0; s < 4 * count && items_sent < stop_at; s++) begin
        case ($urandom_range(9))
          0: send_request(KIND_QUERY, 12'($urandom), 13'($urandom), 13'($urandom),
                          10'($urandom), 10'($urandom_range(count - 1)));
          1: send_request(KIND_QUERY, '0, '0, '0, '0, 10'($urandom));
          2: send_request(3'($urandom_range(5, 7)), 12'($urandom), 13'($urandom),
                          13'($urandom), 10'($urandom), 10'($urandom));
          3: send_request(KIND_RANGE, 12'($urandom_range(NODES, 4095)), 13'($urandom),
                          13'($urandom));
          default: send_request(KIND_STEP, 12'($urandom), 13'($urandom), 13'($urandom),
                                10'($urandom), 10'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    sh_depth = 0;
    sh_start_node = '0;
    foreach (sh_on_stack[i]) begin
      sh_on_stack[i] = 1'b0;
      sh_finished[i] = 1'b0;
    end
    send_idle_pct = 14;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_walks(160);
    send_idle_pct = 62;
    test_random_walks(160);
    send_idle_pct = 0;
    test_random_walks(160);
    write_start_node(10'h3FF);
    write_start_node(10'h000);
    drain_results();
    if (mismatches == 0 && !timed_out) begin
      $display("** dfs_graph_walk_engine_top: PASSED **");
    end else begin
      $display("** dfs_graph_walk_engine_top: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    wait (cycles >= LIMIT_CYCLES);
    timed_out = 1'b1;
    $display("** dfs_graph_walk_engine_top: FAILED **");
    $finish;
  end

endmodule

>>> dfs_graph_walk_engine_top.f
+incdir+src
src/dgw_pkg.sv
src/dgw_ctrl.sv
src/dgw_datapath.sv
src/dfs_graph_walk_engine_top.sv
src/dgw_checker.sv
verif/dfs_graph_walk_engine_top_tb.sv
